FILE: src/pwbd_pkg.sv
// ----------------------------------------------------------------------------
// Pulse-width bus byte decoder package
// Shared constants, configuration codes, field codes and the queue item type.
// ----------------------------------------------------------------------------
package pwbd_pkg;

  // Fixed field widths.
  localparam int PULSE_W    = 24;
  localparam int PERIOD_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERTED           = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_V2        = 2'd2;

  localparam logic [PERIOD_W-1:0] SAMPLES_PER_PERIOD_RESET = 16'd64;

  // Result event kinds.
  localparam logic EVENT_BYTE    = 1'b0;
  localparam logic EVENT_RESTART = 1'b1;

  // Packet field kinds.
  localparam logic [2:0] FIELD_PRIORITY = 3'd0;
  localparam logic [2:0] FIELD_SOURCE   = 3'd1;
  localparam logic [2:0] FIELD_DEST     = 3'd2;
  localparam logic [2:0] FIELD_COMMAND  = 3'd3;
  localparam logic [2:0] FIELD_SIZE     = 3'd4;
  localparam logic [2:0] FIELD_PAYLOAD  = 3'd5;
  localparam logic [2:0] FIELD_CHECK    = 3'd6;
  localparam logic [2:0] FIELD_BEYOND   = 3'd7;

  // Protocol constants.
  localparam int RESTART_PERIODS = 7;
  localparam int STUFF_RUN       = 4;
  localparam int CHECK_OFFSET    = 5;
  localparam int V1_START_BIT    = 6;
  localparam int V2_START_BIT    = 5;
  localparam int BYTE_COUNT_MAX  = 511;

  // Queue between the front and back parts; depth is a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration seen by both parts.
  typedef struct packed {
    logic [PERIOD_W-1:0] samples_per_period;
    logic                inverted;
    logic                protocol_v2;
  } pwbd_cfg_t;

  // A classified pulse of one or more whole periods.
  typedef struct packed {
    logic       bit_state;    // decoded line level after the edge
    logic [4:0] periods_lo;   // period count modulo 32
    logic       long_pulse;   // seven or more periods
    logic       over_four;    // more than four periods
    logic       two_or_more;  // two or more periods
  } pwbd_item_t;

endpackage

FILE: src/pwbd_if.sv
// ----------------------------------------------------------------------------
// Pulse-width bus byte decoder channels
// Valid/ready stream interfaces for edge items and decoded results.
// ----------------------------------------------------------------------------
interface pwbd_in_if;
  import pwbd_pkg::*;

  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] pulse_samples;
  logic               line_level;

  modport source (output valid, output pulse_samples, output line_level, input ready);
  modport sink   (input valid, input pulse_samples, input line_level, output ready);
endinterface

interface pwbd_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [7:0] byte_value;
  logic [2:0] field_kind;
  logic [7:0] payload_index;

  modport source (output valid, output event_kind, output byte_value,
                  output field_kind, output payload_index, input ready);
  modport sink   (input valid, input event_kind, input byte_value,
                  input field_kind, input payload_index, output ready);
endinterface

FILE: src/pwbd_front.sv
// ----------------------------------------------------------------------------
// Pulse-width bus byte decoder front part
// Accepts edge items, adds carried samples and rounds the length to whole
// periods with a bit-serial restoring divider, then classifies the pulse.
// ----------------------------------------------------------------------------
module pwbd_front #(
  parameter int SAMPLE_COUNT_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pwbd_pkg::pwbd_cfg_t   cfg_i,
  pwbd_in_if.sink               in_i,
  output logic                  push_valid_o,
  output pwbd_pkg::pwbd_item_t  push_item_o,
  input  logic                  push_ready_i
);
  import pwbd_pkg::*;

  localparam int SW = SAMPLE_COUNT_BITS;
  localparam int PW = (SW < PULSE_W) ? SW : PULSE_W;
  localparam int NW = ((SW > PERIOD_W) ? SW : PERIOD_W) + 1;
  localparam int CW = $clog2(NW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } state_e;

  state_e              state_q, state_d;
  logic [SW-1:0]       carry_q, carry_d;
  logic [SW-1:0]       total_q, total_d;
  logic [NW-1:0]       num_q, num_d;
  logic [NW-1:0]       quot_q, quot_d;
  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                bit_q, bit_d;

  logic [PERIOD_W-1:0] period_eff;
  logic [SW-1:0]       pulse_ext;
  logic [SW:0]         sum;
  logic [SW-1:0]       total;
  logic [NW-1:0]       numer;
  logic [PERIOD_W+1:0] trial;
  logic                fits;
  logic [PERIOD_W-1:0] rem_next;
  logic                accept;

  // A zero period length counts as one sample.
  assign period_eff = (cfg_i.samples_per_period == '0) ? PERIOD_W'(1)
                                                       : cfg_i.samples_per_period;

  // Carried plus new samples, saturated to the counter width.
  always_comb begin
    pulse_ext = '0;
    pulse_ext[PW-1:0] = in_i.pulse_samples[PW-1:0];
  end
  assign sum   = {1'b0, carry_q} + {1'b0, pulse_ext};
  assign total = sum[SW] ? '1 : sum[SW-1:0];
  assign numer = NW'(total) + NW'(period_eff >> 1);

  // One restoring division step per cycle, numerator MSB first.
  assign trial    = {1'b0, rem_q, num_q[NW-1]} - {2'b00, period_eff};
  assign fits     = !trial[PERIOD_W+1];
  assign rem_next = fits ? trial[PERIOD_W-1:0] : {rem_q[PERIOD_W-2:0], num_q[NW-1]};

  assign accept       = in_i.valid && (state_q == ST_IDLE);
  assign in_i.ready   = (state_q == ST_IDLE);
  assign push_valid_o = (state_q == ST_PUSH) && (quot_q != '0);

  // Classification of the rounded period count.
  always_comb begin
    push_item_o.bit_state   = bit_q;
    push_item_o.periods_lo  = quot_q[4:0];
    push_item_o.long_pulse  = (quot_q >= NW'(RESTART_PERIODS));
    push_item_o.over_four   = (quot_q > NW'(STUFF_RUN));
    push_item_o.two_or_more = (quot_q >= NW'(2));
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    carry_d = carry_q;
    total_d = total_q;
    num_d   = num_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          total_d = total;
          num_d   = numer;
          quot_d  = '0;
          rem_d   = '0;
          cnt_d   = CW'(NW - 1);
          bit_d   = in_i.line_level ^ cfg_i.inverted;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        num_d  = {num_q[NW-2:0], 1'b0};
        rem_d  = rem_next;
        quot_d = {quot_q[NW-2:0], fits};
        cnt_d  = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (quot_q == '0) begin
          // Too short for a period: keep the length for the next pulse.
          carry_d = total_q;
          state_d = ST_IDLE;
        end else if (push_ready_i) begin
          carry_d = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      carry_q <= '0;
      total_q <= '0;
      num_q   <= '0;
      quot_q  <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      bit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      carry_q <= carry_d;
      total_q <= total_d;
      num_q   <= num_d;
      quot_q  <= quot_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
    end
  end

  // A pulse handed to the queue leaves no carried samples behind.
  a_carry_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o && push_ready_i |=> carry_q == '0 && state_q == ST_IDLE)
    else $error("carried samples not cleared after a transfer to the queue");

endmodule

FILE: src/pwbd_queue.sv
// ----------------------------------------------------------------------------
// Pulse-width bus byte decoder queue
// Short first-in first-out buffer of classified pulses between the parts.
// ----------------------------------------------------------------------------
module pwbd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  input  pwbd_pkg::pwbd_item_t  push_item_i,
  output logic                  push_ready_o,
  output logic                  pop_valid_o,
  output pwbd_pkg::pwbd_item_t  pop_item_o,
  input  logic                  pop_ready_i
);
  import pwbd_pkg::*;

  pwbd_item_t        entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entries_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond its depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + QCNT_W'(1))
    else $error("queue fill count did not follow a lone transfer in");

endmodule

FILE: src/pwbd_back.sv
// ----------------------------------------------------------------------------
// Pulse-width bus byte decoder back part
// Assembles bytes from classified pulses for both protocol versions, tags
// each byte with its packet field and holds the result in an output register.
// ----------------------------------------------------------------------------
module pwbd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pwbd_pkg::pwbd_cfg_t   cfg_i,
  input  logic                  pop_valid_i,
  input  pwbd_pkg::pwbd_item_t  pop_item_i,
  output logic                  pop_ready_o,
  pwbd_out_if.source            out_o
);
  import pwbd_pkg::*;

  logic [7:0] acc_q, acc_d;
  logic [4:0] bitpos_q, bitpos_d;
  logic [8:0] bytecnt_q, bytecnt_d;
  logic [7:0] size_q, size_d;
  logic       stuff_q, stuff_d;

  logic       out_valid_q, out_valid_d;
  logic       out_kind_q, out_kind_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic [2:0] out_field_q, out_field_d;
  logic [7:0] out_index_q, out_index_d;

  logic       take;
  logic       restart;
  logic       emit;
  logic [7:0] emit_val;
  logic [7:0] acc_n;
  logic [7:0] mask;
  logic [4:0] bp_sum;
  logic [8:0] check_at;
  logic [8:0] pay_idx;

  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign take        = pop_valid_i && pop_ready_o;
  assign restart     = pop_item_i.long_pulse &&
                       ((!cfg_i.protocol_v2) == pop_item_i.bit_state);
  assign check_at    = 9'(CHECK_OFFSET) + {1'b0, size_q};
  assign pay_idx     = bytecnt_q - 9'(CHECK_OFFSET);

  // Bit assembly and field tagging.
  always_comb begin
    acc_d       = acc_q;
    bitpos_d    = bitpos_q;
    bytecnt_d   = bytecnt_q;
    size_d      = size_q;
    stuff_d     = stuff_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_field_d = out_field_q;
    out_index_d = out_index_q;
    emit        = 1'b0;
    emit_val    = acc_q;
    acc_n       = acc_q;
    mask        = 8'hFF >> bitpos_q;
    bp_sum      = bitpos_q;

    if (take) begin
      if (restart) begin
        acc_d       = '0;
        bitpos_d    = cfg_i.protocol_v2 ? 5'(V2_START_BIT) : 5'(V1_START_BIT);
        bytecnt_d   = '0;
        stuff_d     = 1'b1;
        out_valid_d = 1'b1;
        out_kind_d  = EVENT_RESTART;
        out_byte_d  = '0;
        out_field_d = FIELD_PRIORITY;
        out_index_d = '0;
      end else if (cfg_i.protocol_v2) begin
        // Run of equal bits; the first period after a long run is stuffing.
        acc_n  = pop_item_i.bit_state ? (acc_q | mask) : (acc_q & ~mask);
        bp_sum = bitpos_q + pop_item_i.periods_lo - 5'(stuff_q);
        if (bp_sum[3]) begin
          bitpos_d = {2'b00, bp_sum[2:0]};
          emit     = 1'b1;
          emit_val = acc_n;
          acc_d    = pop_item_i.bit_state ? 8'hFF : 8'h00;
        end else begin
          bitpos_d = bp_sum;
          acc_d    = acc_n;
        end
        stuff_d = pop_item_i.over_four;
      end else if (pop_item_i.bit_state) begin
        // One bit per low pulse: a wide pulse is a one.
        acc_n  = pop_item_i.two_or_more ? (acc_q | (8'h80 >> bitpos_q)) : acc_q;
        bp_sum = bitpos_q + 5'd1;
        if (bp_sum[3]) begin
          bitpos_d = '0;
          emit     = 1'b1;
          emit_val = acc_n;
          acc_d    = '0;
        end else begin
          bitpos_d = bp_sum;
          acc_d    = acc_n;
        end
      end
    end

    // Field of the finished byte from its place in the packet.
    if (emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = EVENT_BYTE;
      out_byte_d  = emit_val;
      out_index_d = '0;
      unique case (bytecnt_q)
        9'd0: out_field_d = FIELD_PRIORITY;
        9'd1: out_field_d = cfg_i.protocol_v2 ? FIELD_DEST : FIELD_SOURCE;
        9'd2: out_field_d = cfg_i.protocol_v2 ? FIELD_SOURCE : FIELD_DEST;
        9'd3: out_field_d = FIELD_COMMAND;
        9'd4: begin
          out_field_d = FIELD_SIZE;
          size_d      = emit_val;
        end
        default: begin
          if (bytecnt_q < check_at) begin
            out_field_d = FIELD_PAYLOAD;
            out_index_d = pay_idx[7:0];
          end else if (bytecnt_q == check_at) begin
            out_field_d = FIELD_CHECK;
          end else begin
            out_field_d = FIELD_BEYOND;
          end
        end
      endcase
      if (bytecnt_q != 9'(BYTE_COUNT_MAX)) begin
        bytecnt_d = bytecnt_q + 9'd1;
      end
    end
  end

  // Decoder state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      bitpos_q    <= 5'(V1_START_BIT);
      bytecnt_q   <= '0;
      size_q      <= '0;
      stuff_q     <= 1'b1;
      out_valid_q <= 1'b0;
      out_kind_q  <= EVENT_BYTE;
      out_byte_q  <= '0;
      out_field_q <= FIELD_PRIORITY;
      out_index_q <= '0;
    end else begin
      acc_q       <= acc_d;
      bitpos_q    <= bitpos_d;
      bytecnt_q   <= bytecnt_d;
      size_q      <= size_d;
      stuff_q     <= stuff_d;
      out_valid_q <= out_valid_d;
      out_kind_q  <= out_kind_d;
      out_byte_q  <= out_byte_d;
      out_field_q <= out_field_d;
      out_index_q <= out_index_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.event_kind    = out_kind_q;
  assign out_o.byte_value    = out_byte_q;
  assign out_o.field_kind    = out_field_q;
  assign out_o.payload_index = out_index_q;

  a_restart_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && restart |=> bytecnt_q == '0 && stuff_q &&
      (bitpos_q == 5'(V1_START_BIT) || bitpos_q == 5'(V2_START_BIT)))
    else $error("frame restart did not reset the byte assembly");

  a_restart_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.event_kind == EVENT_RESTART |->
      out_o.byte_value == '0 && out_o.field_kind == FIELD_PRIORITY &&
      out_o.payload_index == '0)
    else $error("restart result carries byte data");

endmodule

FILE: src/pulse_width_bus_byte_decoder.sv
// ----------------------------------------------------------------------------
// Pulse-width bus byte decoder
// Top level: configuration registers, front part, queue and back part.
// ----------------------------------------------------------------------------
// Usage:
// - in_i carries one edge per transfer: the samples since the previous edge
//   and the line level after it. out_o carries decoded bytes with their
//   packet field, or a frame restart marker.
// - The front part rounds the pulse to whole bit periods with a bit-serial
//   divider, one quotient bit per cycle. It takes no new edge while it
//   divides or waits for the queue to take the pulse; in_i is ready again
//   once the pulse is handed on, or its samples are carried to the next.
// - A result passes from the front part through the queue and the back
//   part's output register to out_o.
// - The back part handles one queued pulse per cycle while out_o is ready or
//   its output register is empty. A two-entry queue and that register let
//   the front part keep dividing while out_o stalls; when full, in_i stalls.
// - Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i
//   while the block is idle. Reset sets a period of 64 samples, no
//   inversion, version 1 and an empty frame; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pulse_width_bus_byte_decoder #(
  parameter int SAMPLE_COUNT_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pwbd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pwbd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  pwbd_in_if.sink                             in_i,
  pwbd_out_if.source                          out_o
);
  import pwbd_pkg::*;

  logic [PERIOD_W-1:0] spp_q;
  logic                inverted_q;
  logic                v2_q;
  pwbd_cfg_t           cfg;

  logic       push_valid, push_ready;
  pwbd_item_t push_item;
  logic       pop_valid, pop_ready;
  pwbd_item_t pop_item;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spp_q      <= SAMPLES_PER_PERIOD_RESET;
      inverted_q <= 1'b0;
      v2_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SAMPLES_PER_PERIOD: spp_q      <= cfg_data_i[PERIOD_W-1:0];
        REG_INVERTED:           inverted_q <= cfg_data_i[0];
        REG_PROTOCOL_V2:        v2_q       <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.samples_per_period = spp_q;
  assign cfg.inverted           = inverted_q;
  assign cfg.protocol_v2        = v2_q;

  pwbd_front #(
    .SAMPLE_COUNT_BITS (SAMPLE_COUNT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  pwbd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  pwbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pulse-width bus byte decoder testbench
// Drives timed edges into the decoder under both protocol versions, with
// inversion, extreme bit periods, glitches, noise and one very long frame.
// Every result transfer is checked against a local decoder model or a plan row.
// ----------------------------------------------------------------------------
module tb;
  import pwbd_pkg::*;

  localparam int SAMPLE_BITS = 24;
  localparam longint unsigned SAMPLE_MAX = (64'd1 << SAMPLE_BITS) - 1;
  // Results trail the edge transfer; this wait covers the delay.
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 50;

  typedef struct packed {
    logic       event_kind;
    logic [7:0] byte_value;
    logic [2:0] field_kind;
    logic [7:0] payload_index;
  } bus_event_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
    logic [PULSE_W-1:0]    samples;
    logic                  level;
    bit                    typed;
    bus_event_t            result;
  } plan_row_t;

  localparam bus_event_t RESTART_EV = '{EVENT_RESTART, 8'd0, FIELD_PRIORITY, 8'd0};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pwbd_in_if  in_ch ();
  pwbd_out_if out_ch ();

  pulse_width_bus_byte_decoder #(
    .SAMPLE_COUNT_BITS(SAMPLE_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Decoder model: register copies and frame state, at reset values.
  logic [PERIOD_W-1:0] cfg_period   = SAMPLES_PER_PERIOD_RESET;
  logic                cfg_inverted = 1'b0;
  logic                cfg_v2       = 1'b0;
  logic [PULSE_W-1:0]  st_carry      = '0;
  logic [7:0]          st_acc        = '0;
  logic [4:0]          st_bit_pos    = 5'(V1_START_BIT);
  logic [8:0]          st_byte_count = '0;
  logic [7:0]          st_size       = '0;
  logic                st_stuff      = 1'b1;

  bus_event_t expected_events[$];
  plan_row_t  plan[$];
  int         mismatch_count = 0;
  int         stall_cycles   = 0;
  int         hold_out       = 0;
  bit         in_calm        = 1'b0;
  bit         out_calm       = 1'b0;
  bit         typed_armed    = 1'b0;
  bus_event_t typed_result   = '0;

  always #5 clk_i = ~clk_i;

  // Names the packet field of the finished byte and advances the byte count.
  function automatic bus_event_t classify_byte();
    bus_event_t ev;
    int         check_at;
    ev = '0;
    ev.event_kind = EVENT_BYTE;
    ev.byte_value = st_acc;
    check_at = CHECK_OFFSET + st_size;
    if (st_byte_count == 0) begin
      ev.field_kind = FIELD_PRIORITY;
    end else if (st_byte_count == 1) begin
      ev.field_kind = cfg_v2 ? FIELD_DEST : FIELD_SOURCE;
    end else if (st_byte_count == 2) begin
      ev.field_kind = cfg_v2 ? FIELD_SOURCE : FIELD_DEST;
    end else if (st_byte_count == 3) begin
      ev.field_kind = FIELD_COMMAND;
    end else if (st_byte_count == 4) begin
      ev.field_kind = FIELD_SIZE;
      st_size = st_acc;
    end else if (st_byte_count < check_at) begin
      ev.field_kind    = FIELD_PAYLOAD;
      ev.payload_index = 8'(st_byte_count - CHECK_OFFSET);
    end else if (st_byte_count == check_at) begin
      ev.field_kind = FIELD_CHECK;
    end else begin
      ev.field_kind = FIELD_BEYOND;
    end
    if (st_byte_count < BYTE_COUNT_MAX) st_byte_count++;
    return ev;
  endfunction

  // Decodes one edge; returns 1 when the edge yields a result in ev.
  function automatic bit decode_edge(input logic [PULSE_W-1:0] samples, input logic level,
                                     output bus_event_t ev);
    logic              bit_state;
    longint unsigned   t, total, periods;
    logic [4:0]        step;
    logic [7:0]        mask;
    bit                emitted;
    ev = '0;
    emitted = 1'b0;
    bit_state = level ^ cfg_inverted;
    t = (cfg_period == 0) ? 1 : cfg_period;
    total = st_carry + samples;
    if (total > SAMPLE_MAX) total = SAMPLE_MAX;
    periods = (total + t / 2) / t;
    // A glitch shorter than half a period is folded into the next pulse.
    if (periods == 0) begin
      st_carry = total;
      return 1'b0;
    end
    st_carry = '0;
    if (periods >= RESTART_PERIODS && ((cfg_v2 == 1'b0) == (bit_state == 1'b1))) begin
      st_acc        = '0;
      st_bit_pos    = cfg_v2 ? 5'(V2_START_BIT) : 5'(V1_START_BIT);
      st_byte_count = '0;
      st_stuff      = 1'b1;
      ev            = RESTART_EV;
      return 1'b1;
    end
    if (cfg_v2) begin
      // A run fills the remaining bits with its level, then skips the stuff bit.
      mask = 8'hFF >> st_bit_pos;
      if (bit_state) st_acc |= mask;
      else st_acc &= ~mask;
      step = periods[4:0] - st_stuff;
      st_bit_pos = st_bit_pos + step;
      if (st_bit_pos[3]) begin
        st_bit_pos = st_bit_pos & 5'd7;
        ev = classify_byte();
        emitted = 1'b1;
        st_acc = bit_state ? 8'hFF : 8'h00;
      end
      st_stuff = (periods > STUFF_RUN);
    end else if (bit_state) begin
      // Version 1: a low pulse of two or more periods is a one.
      if (periods >= 2) st_acc |= 8'h80 >> st_bit_pos;
      st_bit_pos = st_bit_pos + 5'd1;
      if (st_bit_pos[3]) begin
        st_bit_pos = '0;
        ev = classify_byte();
        emitted = 1'b1;
        st_acc = '0;
      end
    end
    return emitted;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_event(input bus_event_t got);
    bus_event_t want;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing expected", got));
      return;
    end
    want = expected_events.pop_front();
    if (got.event_kind !== want.event_kind)
      report_mismatch($sformatf("event_kind %0d, expected %0d", got.event_kind,
                                want.event_kind));
    if (got.byte_value !== want.byte_value)
      report_mismatch($sformatf("byte_value %h, expected %h", got.byte_value,
                                want.byte_value));
    if (got.field_kind !== want.field_kind)
      report_mismatch($sformatf("field_kind %0d, expected %0d", got.field_kind,
                                want.field_kind));
    if (got.payload_index !== want.payload_index)
      report_mismatch($sformatf("payload_index %0d, expected %0d", got.payload_index,
                                want.payload_index));
  endtask

  // Result transfers are checked first, then edge transfers feed the model.
  always @(posedge clk_i) begin
    bus_event_t got;
    bus_event_t predicted;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.event_kind, out_ch.byte_value, out_ch.field_kind, out_ch.payload_index};
        check_event(got);
        hold_out = out_calm ? 0 : $urandom_range(0, 5);
      end
      if (in_ch.valid && in_ch.ready) begin
        if (decode_edge(in_ch.pulse_samples, in_ch.line_level, predicted) && !typed_armed)
          expected_events.push_back(predicted);
        if (typed_armed) expected_events.push_back(typed_result);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLES_PER_PERIOD: cfg_period = cfg_data;
          REG_INVERTED:           cfg_inverted = cfg_data[0];
          REG_PROTOCOL_V2:        cfg_v2 = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Result side: stall for the drawn number of cycles after each transfer.
  always @(negedge clk_i) begin
    if (hold_out > 0) begin
      out_ch.ready = 1'b0;
      hold_out--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Offers one edge after a random gap and waits for its transfer.
  task automatic send_edge(input logic [PULSE_W-1:0] samples, input logic level,
                           input bit typed = 1'b0, input bus_event_t result = '0);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    typed_armed         = typed;
    typed_result        = result;
    in_ch.valid         = 1'b1;
    in_ch.pulse_samples = samples;
    in_ch.line_level    = level;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Pulse length that rounds to the given period count, with random jitter.
  function automatic logic [PULSE_W-1:0] pulse_len(input int periods);
    longint unsigned t, lo, hi;
    t  = (cfg_period == 0) ? 1 : cfg_period;
    lo = periods * t - t / 2;
    hi = periods * t + (t - t / 2) - 1;
    return PULSE_W'($urandom_range(32'(hi), 32'(lo)));
  endfunction

  task automatic send_bit(input logic decoded, input int periods);
    send_edge(pulse_len(periods), decoded ^ cfg_inverted);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_edge(PULSE_W'($urandom), 1'($urandom));
      1: send_edge(PULSE_W'($urandom_range(0, cfg_period)), 1'($urandom));
      default: send_bit(1'($urandom), $urandom_range(1, 20));
    endcase
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0) send_noise();
  endtask

  // Version 1 byte: one low pulse per bit, with an odd ignored high pulse.
  task automatic send_v1_byte(input logic [7:0] value, input int first_pos);
    maybe_noise();
    for (int p = first_pos; p < 8; p++) begin
      if ($urandom_range(0, 7) == 0) send_bit(1'b0, $urandom_range(1, 8));
      send_bit(1'b1, value[7-p] ? $urandom_range(2, 3) : 1);
    end
  endtask

  task automatic v1_frame();
    int size;
    int tail;
    size = $urandom_range(0, 3);
    tail = size + 1 + $urandom_range(0, 2);
    send_bit(1'b1, $urandom_range(7, 12));
    send_v1_byte(8'($urandom), V1_START_BIT);
    repeat (3) send_v1_byte(8'($urandom), 0);
    send_v1_byte(8'(size), 0);
    repeat (tail) send_v1_byte(8'($urandom), 0);
  endtask

  // Version 2 frame: alternating runs; low runs stay short of a restart.
  task automatic v2_frame();
    int   runs;
    logic lvl;
    send_bit(1'b0, $urandom_range(7, 12));
    lvl  = 1'b1;
    runs = $urandom_range(15, 40);
    repeat (runs) begin
      maybe_noise();
      send_bit(lvl, lvl ? $urandom_range(1, 10) : $urandom_range(1, 6));
      lvl = ~lvl;
    end
  endtask

  // Long high runs give about one byte each, on past the byte count saturating.
  task automatic long_v2_frame();
    int tail;
    tail = 0;
    send_bit(1'b0, RESTART_PERIODS);
    while (st_byte_count < BYTE_COUNT_MAX || tail < 12) begin
      if (st_byte_count >= BYTE_COUNT_MAX) tail++;
      if ($urandom_range(0, 4) == 0) send_bit(1'b0, $urandom_range(1, 4));
      else send_bit(1'b1, $urandom_range(9, 10));
    end
  endtask

  // Waits for every expected result, then for work that yields none.
  task automatic wait_idle();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (expected_events.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  task automatic set_mode(input logic v2, input logic inv, input logic [CFG_DATA_W-1:0] period);
    wait_idle();
    write_reg(REG_SAMPLES_PER_PERIOD, period);
    write_reg(REG_INVERTED, CFG_DATA_W'(inv));
    write_reg(REG_PROTOCOL_V2, CFG_DATA_W'(v2));
    in_calm  = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
  endtask

  function automatic bus_event_t byte_ev(input logic [7:0] value, input logic [2:0] field);
    return '{EVENT_BYTE, value, field, 8'd0};
  endfunction

  function automatic plan_row_t pulse_row(input logic [PULSE_W-1:0] samples, input logic level);
    plan_row_t r;
    r = '{default: '0};
    r.samples = samples;
    r.level   = level;
    return r;
  endfunction

  function automatic plan_row_t checked_row(input logic [PULSE_W-1:0] samples, input logic level,
                                            input bus_event_t result);
    plan_row_t r;
    r = pulse_row(samples, level);
    r.typed  = 1'b1;
    r.result = result;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] value);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg    = 1'b1;
    r.reg_index = idx;
    r.reg_value = value;
    return r;
  endfunction

  initial begin
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.pulse_samples = '0;
    in_ch.line_level    = 1'b0;
    out_ch.ready        = 1'b0;

    // Version 1 at reset values: restart, glitch carry, ignored high pulse.
    plan.push_back(checked_row(448, 1'b1, RESTART_EV));
    plan.push_back(pulse_row(0, 1'b1));
    plan.push_back(pulse_row(31, 1'b1));
    plan.push_back(pulse_row(1, 1'b0));
    plan.push_back(pulse_row(128, 1'b1));
    plan.push_back(checked_row(64, 1'b1, byte_ev(8'h02, FIELD_PRIORITY)));
    plan.push_back(pulse_row(24'hFFFFFF, 1'b0));
    plan.push_back(checked_row(24'hFFFFFF, 1'b1, RESTART_EV));
    // A zero period register behaves as one sample.
    plan.push_back(cfg_row(REG_SAMPLES_PER_PERIOD, 16'd0));
    plan.push_back(pulse_row(3, 1'b1));
    plan.push_back(checked_row(1, 1'b1, byte_ev(8'h02, FIELD_PRIORITY)));
    // Longest period with the line inverted.
    plan.push_back(cfg_row(REG_SAMPLES_PER_PERIOD, 16'hFFFF));
    plan.push_back(cfg_row(REG_INVERTED, 16'd1));
    plan.push_back(checked_row(24'hFFFFFF, 1'b0, RESTART_EV));
    plan.push_back(pulse_row(32767, 1'b1));
    plan.push_back(pulse_row(1, 1'b1));
    // Version 2: runs, stuffing, swapped address fields, count saturation.
    plan.push_back(cfg_row(REG_PROTOCOL_V2, 16'd1));
    plan.push_back(cfg_row(REG_SAMPLES_PER_PERIOD, 16'd8));
    plan.push_back(cfg_row(REG_INVERTED, 16'd0));
    plan.push_back(checked_row(56, 1'b0, RESTART_EV));
    plan.push_back(checked_row(40, 1'b1, byte_ev(8'h07, FIELD_PRIORITY)));
    plan.push_back(pulse_row(8, 1'b0));
    plan.push_back(pulse_row(32, 1'b1));
    plan.push_back(checked_row(24, 1'b0, byte_ev(8'hF8, FIELD_DEST)));
    plan.push_back(checked_row(72, 1'b1, byte_ev(8'hFF, FIELD_SOURCE)));
    plan.push_back(pulse_row(24'hFFFFFF, 1'b1));
    plan.push_back(pulse_row(3, 1'b1));
    plan.push_back(checked_row(24'hFFFFFF, 1'b0, RESTART_EV));

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].reg_index, plan[i].reg_value);
      end else begin
        send_edge(plan[i].samples, plan[i].level, plan[i].typed, plan[i].result);
      end
    end

    // Random frames over several settings, the period extremes among them.
    set_mode(1'b0, 1'b0, 16'd1);
    v1_frame();
    set_mode(1'b1, 1'b1, 16'hFFFF);
    v2_frame();
    v2_frame();
    set_mode(1'b0, 1'b1, 16'($urandom_range(2, 300)));
    v1_frame();
    set_mode(1'b1, 1'b0, 16'($urandom_range(3, 40)));
    v2_frame();
    v2_frame();
    set_mode(1'b1, 1'($urandom), 16'($urandom_range(2, 20)));
    long_v2_frame();
    set_mode(1'($urandom), 1'($urandom), 16'($urandom_range(1, 50)));
    repeat (40) send_noise();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: pulse_width_bus_byte_decoder.f
src/pwbd_pkg.sv
src/pwbd_if.sv
src/pwbd_front.sv
src/pwbd_queue.sv
src/pwbd_back.sv
src/pulse_width_bus_byte_decoder.sv
tb/sv/tb.sv
